@@ rtl/prefix_varint_codec_top_defines.svh @@
// assertion macros shared by pvc_decoder and the top module
// each expects clk_i and rst_ni in the scope where it is used
`ifndef PREFIX_VARINT_CODEC_TOP_DEFINES_SVH
`define PREFIX_VARINT_CODEC_TOP_DEFINES_SVH

// same-cycle implication
`define PVC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pvc_pkg.sv @@
package pvc_pkg;

  // operation codes of an input item
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // result kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  // longest code in bytes (0xff first byte)
  localparam logic [3:0] MAX_CODE_LEN = 4'd9;
  // longest code whose length prefix ends in a zero bit
  localparam int PREFIX_CODE_LEN = 8;
  // payload bits per byte of a prefixed code
  localparam int BITS_PER_BYTE = 7;

  // input item
  typedef struct packed {
    logic        opcode;
    logic [63:0] value_in;
    logic [7:0]  byte_in;
  } pvc_in_t;

  // result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_out;
    logic [63:0] value_out;
    logic [3:0]  code_length;
    logic        last;
  } pvc_out_t;

  // one encoded byte from the encoder
  typedef struct packed {
    logic [7:0] byte_out;
    logic [3:0] len;
    logic       last;
  } pvc_enc_t;

  // completed value from the decoder
  typedef struct packed {
    logic        valid;
    logic [63:0] value;
    logic [3:0]  len;
  } pvc_dec_t;

endpackage

@@ rtl/pvc_encoder.sv @@
module pvc_encoder (
  input  logic [63:0]     value_i,
  input  logic [3:0]      idx_i,
  output pvc_pkg::pvc_enc_t enc_o
);

  logic [3:0] len;
  logic [3:0] sel;
  logic [7:0] prefix;
  logic [7:0] data;

  // shortest code that holds the value, nine bytes when nothing smaller fits
  always_comb begin
    len = pvc_pkg::MAX_CODE_LEN;
    for (int i = pvc_pkg::PREFIX_CODE_LEN; i >= 1; i--) begin
      if ((value_i >> (pvc_pkg::BITS_PER_BYTE * i)) == 64'd0) begin
        len = 4'(i);
      end
    end
  end

  // byte position within the value, counted from the least significant byte
  assign sel    = len - 4'd1 - idx_i;
  assign prefix = ~(8'hff >> (len - 4'd1));

  always_comb begin
    if (sel[3]) begin
      data = 8'h00;
    end else begin
      data = value_i[{sel[2:0], 3'b000} +: 8];
    end
  end

  // first byte carries the unary length prefix
  always_comb begin
    enc_o.byte_out = ((idx_i == 4'd0) ? prefix : 8'h00) | data;
    enc_o.len      = len;
    enc_o.last     = (idx_i == (len - 4'd1));
  end

endmodule

@@ rtl/pvc_decoder.sv @@
`include "prefix_varint_codec_top_defines.svh"

module pvc_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        byte_i,
  output pvc_pkg::pvc_dec_t res_o
);

  logic [3:0]  rem_q, rem_d;
  logic [63:0] part_q, part_d;
  logic [3:0]  dlen_q, dlen_d;

  logic [3:0]  first_len;
  logic        run;
  logic [3:0]  rem_n;
  logic [63:0] part_n;
  logic [3:0]  dlen_n;

  // code length from the leading ones of a first byte
  always_comb begin
    first_len = 4'd1;
    run       = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && byte_i[i]) begin
        first_len = first_len + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  // gather the incoming byte
  always_comb begin
    if (rem_q == 4'd0) begin
      part_n = {56'd0, byte_i & (8'hff >> first_len)};
      dlen_n = first_len;
      rem_n  = first_len - 4'd1;
    end else begin
      part_n = {part_q[55:0], byte_i};
      dlen_n = dlen_q;
      rem_n  = rem_q - 4'd1;
    end
  end

  // completed value
  always_comb begin
    res_o.valid = en_i && (rem_n == 4'd0);
    res_o.value = part_n;
    res_o.len   = dlen_n;
  end

  // state update, cleared once a code completes
  always_comb begin
    rem_d  = rem_q;
    part_d = part_q;
    dlen_d = dlen_q;
    if (en_i) begin
      if (rem_n == 4'd0) begin
        rem_d  = 4'd0;
        part_d = 64'd0;
        dlen_d = 4'd0;
      end else begin
        rem_d  = rem_n;
        part_d = part_n;
        dlen_d = dlen_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 4'd0;
      part_q <= 64'd0;
      dlen_q <= 4'd0;
    end else begin
      rem_q  <= rem_d;
      part_q <= part_d;
      dlen_q <= dlen_d;
    end
  end

  // checks on the decode state
  `PVC_ASSERT_IMPL(a_rem_range, 1'b1, rem_q <= 4'd8, "bytes remaining out of range")
  `PVC_ASSERT_IMPL(a_idle_clear, rem_q == 4'd0, (part_q == 64'd0) && (dlen_q == 4'd0),
                   "decode state not cleared between codes")
  `PVC_ASSERT_IMPL(a_len_cover, rem_q != 4'd0, dlen_q > rem_q,
                   "code length does not cover the missing bytes")

endmodule

@@ rtl/prefix_varint_codec_top.sv @@
// Prefix varint codec: encodes 64-bit values into 1 to 9 byte codes with a
// unary leading-ones length prefix, and decodes such codes one byte at a time.
// Input channel: in_valid_i / in_stall_o carry one item per transfer; the
// opcode picks encode (value_in) or decode (byte_in).
// Output channel: out_valid_o / out_stall_i carry one result per transfer.
// An encode item gives code_length byte results, most significant first, the
// final one with last set. A decode item gives a value result when it ends a
// code and nothing otherwise; a partial code survives encode items.
// An item is held in the input register, and each of its results is then
// registered in the output register, from which it can transfer. A decode
// item leaves the input register when it steps; an encode item holds it until
// its last byte, one output byte per cycle while out_stall_i is low.
// The output register frees up as its result transfers, so a new item is
// taken in the same cycle that the previous one finishes.
// When the receiver stalls, the output register holds its result and the
// input register holds its item; in_stall_o rises once that register is full.
// Reset empties both registers and clears the decode state.
`include "prefix_varint_codec_top_defines.svh"

module prefix_varint_codec_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pvc_pkg::pvc_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pvc_pkg::pvc_out_t out_data_o
);

  logic              stg_valid_q, stg_valid_d;
  pvc_pkg::pvc_in_t  stg_q, stg_d;
  logic [3:0]        idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  pvc_pkg::pvc_out_t out_q, out_d;

  logic              advance;
  logic              is_enc;
  logic              step;
  logic              finish;
  logic              take;
  pvc_pkg::pvc_enc_t enc;
  pvc_pkg::pvc_dec_t dec;

  // handshake control
  assign advance    = !out_valid_q || !out_stall_i;
  assign is_enc     = (stg_q.opcode == pvc_pkg::OP_ENCODE);
  assign step       = stg_valid_q && advance;
  assign finish     = step && (!is_enc || enc.last);
  assign in_stall_o = stg_valid_q && !finish;
  assign take       = in_valid_i && !in_stall_o;

  pvc_encoder u_encoder (
    .value_i (stg_q.value_in),
    .idx_i   (idx_q),
    .enc_o   (enc)
  );

  pvc_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step && !is_enc),
    .byte_i (stg_q.byte_in),
    .res_o  (dec)
  );

  // input register and encode byte counter
  always_comb begin
    stg_valid_d = stg_valid_q;
    stg_d       = stg_q;
    idx_d       = idx_q;
    if (take) begin
      stg_valid_d = 1'b1;
      stg_d       = in_data_i;
      idx_d       = 4'd0;
    end else if (finish) begin
      stg_valid_d = 1'b0;
    end else if (step && is_enc) begin
      idx_d = idx_q + 4'd1;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = step && (is_enc || dec.valid);
      if (is_enc) begin
        out_d.kind        = pvc_pkg::KIND_BYTE;
        out_d.byte_out    = enc.byte_out;
        out_d.value_out   = 64'd0;
        out_d.code_length = enc.len;
        out_d.last        = enc.last;
      end else begin
        out_d.kind        = pvc_pkg::KIND_VALUE;
        out_d.byte_out    = 8'h00;
        out_d.value_out   = dec.value;
        out_d.code_length = dec.len;
        out_d.last        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks on the sequencing of encoded bytes and result fields
  `PVC_ASSERT_IMPL(a_idx_range, stg_valid_q && is_enc, idx_q < enc.len,
                   "encode byte index past code length")
  `PVC_ASSERT_NEXT(a_enc_hold, step && is_enc && !enc.last,
                   stg_valid_q && (idx_q == $past(idx_q) + 4'd1),
                   "encode item left before its last byte")
  `PVC_ASSERT_IMPL(a_value_fields,
                   out_valid_q && (out_q.kind == pvc_pkg::KIND_VALUE),
                   out_q.last && (out_q.byte_out == 8'h00),
                   "decoded value result with bad byte or last field")

endmodule
